/* sv/rfs_pkg.sv */
// Package for the ring FIFO with running sum: payload structs, op codes,
// FSM state type and sizing constants. No dependencies.
package rfs_pkg;

    // Depth of the entry store; must be a power of two.
    localparam int unsigned MAX_DEPTH = 64;
    localparam int unsigned ADDR_W    = $clog2(MAX_DEPTH);
    // Indices wrap modulo 2*MAX_DEPTH so full and empty stay distinct.
    localparam int unsigned IDX_W     = ADDR_W + 1;
    localparam int unsigned CNT_W     = 7;
    localparam int unsigned SIZE_W    = 3;
    localparam int unsigned DATA_W    = 32;

    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(ADDR_W);
    localparam logic [SIZE_W-1:0] SIZE_MIN   = SIZE_W'(1);
    localparam logic [SIZE_W-1:0] SIZE_MAX   = SIZE_W'(ADDR_W);

    localparam logic [2:0] OP_PUT      = 3'd0;
    localparam logic [2:0] OP_PUSH     = 3'd1;
    localparam logic [2:0] OP_GET      = 3'd2;
    localparam logic [2:0] OP_PEEK_NEW = 3'd3;
    localparam logic [2:0] OP_PEEK_OLD = 3'd4;

    typedef struct packed {
        logic        [2:0]        op;
        logic signed [DATA_W-1:0] value;
    } t_in_word;

    typedef struct packed {
        logic                     ok;
        logic signed [DATA_W-1:0] data;
        logic        [CNT_W-1:0]  count;
        logic signed [DATA_W-1:0] total;
        logic                     is_empty;
        logic                     is_full;
    } t_out_word;

    // One access request to the entry store.
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [DATA_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_mem_req;

    typedef enum logic {
        S_IDLE,
        S_FIN
    } t_state;

endpackage

/* sv/ring_fifo_with_running_sum.sv */
// An accepted op moves to the finish state after a registered read of the entry store;
// its result is registered when the read-modify-write finish completes, which waits for
// a free output register. o_in_ready is low in the finish state, so no new op is taken then.
// A finished result waits in the output register while the next op is already taken.
// Reset (sync, active low): queue empty, running total 0, size_log2 6.
// A size write also empties the queue; stored words are left in place but unreadable.
module ring_fifo_with_running_sum (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // configuration: size_log2
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [rfs_pkg::SIZE_W-1:0]  i_cfg_data,
    // operation words in
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  rfs_pkg::t_in_word           i_in_word,
    // result words out
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output rfs_pkg::t_out_word          o_out_word
);

    localparam int unsigned AW = rfs_pkg::ADDR_W;
    localparam int unsigned IW = rfs_pkg::IDX_W;
    localparam int unsigned DW = rfs_pkg::DATA_W;

    // ---------------------------------------------------------------
    // Control and queue state
    // ---------------------------------------------------------------
    rfs_pkg::t_state            r_state, n_state;
    logic [rfs_pkg::SIZE_W-1:0] r_size;
    logic [IW-1:0]              r_wr, n_wr;
    logic [IW-1:0]              r_rd, n_rd;
    logic [DW-1:0]              r_total, n_total;
    // Operation latched at acceptance
    logic [2:0]                 r_op;
    logic [DW-1:0]              r_val;
    // Output register
    logic                       r_out_valid;
    rfs_pkg::t_out_word         r_out_word, n_out_word;

    rfs_pkg::t_mem_req          mem_req;
    logic [DW-1:0]              mem_rdata;

    logic                       in_acc;
    logic                       cfg_acc;
    logic                       slot_free;
    logic                       fin;
    logic [rfs_pkg::SIZE_W-1:0] lg;
    logic [IW-1:0]              cap;
    logic [AW-1:0]              mask;
    logic [IW-1:0]              held;
    logic [IW-1:0]              held_new;
    logic [IW-1:0]              wr_prev;

    assign o_cfg_ready = 1'b1;
    assign cfg_acc     = i_cfg_valid & o_cfg_ready;
    assign in_acc      = i_in_valid & o_in_ready;
    // The output register can take a result when empty or being drained.
    assign slot_free   = ~r_out_valid | i_out_ready;
    assign fin         = (r_state == rfs_pkg::S_FIN) & slot_free;

    // Capacity in use: clamp size_log2 into the supported range.
    always_comb begin
        if (r_size < rfs_pkg::SIZE_MIN) begin
            lg = rfs_pkg::SIZE_MIN;
        end else if (r_size > rfs_pkg::SIZE_MAX) begin
            lg = rfs_pkg::SIZE_MAX;
        end else begin
            lg = r_size;
        end
    end

    assign cap     = IW'(1) << lg;
    assign mask    = AW'(cap - IW'(1));
    assign held    = r_wr - r_rd;
    assign wr_prev = r_wr - IW'(1);

    rfs_store u_store (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

    // ---------------------------------------------------------------
    // Next state, memory access and result
    // ---------------------------------------------------------------
    always_comb begin
        n_state    = r_state;
        n_wr       = r_wr;
        n_rd       = r_rd;
        n_total    = r_total;
        n_out_word = r_out_word;
        o_in_ready = 1'b0;
        held_new   = held;

        mem_req       = '0;
        mem_req.waddr = r_wr[AW-1:0] & mask;
        mem_req.wdata = r_val;
        // Newest word for peek-newest, oldest for everything else.
        mem_req.raddr = (i_in_word.op == rfs_pkg::OP_PEEK_NEW) ?
                        (wr_prev[AW-1:0] & mask) : (r_rd[AW-1:0] & mask);

        unique case (r_state)
            rfs_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (in_acc) begin
                    mem_req.re = 1'b1;
                    n_state    = rfs_pkg::S_FIN;
                end
            end
            rfs_pkg::S_FIN: begin
                if (slot_free) begin
                    n_state = rfs_pkg::S_IDLE;
                    n_out_word.ok   = 1'b0;
                    n_out_word.data = '0;
                    unique case (r_op)
                        rfs_pkg::OP_PUT: begin
                            if (held < cap) begin
                                mem_req.we    = 1'b1;
                                n_wr          = r_wr + IW'(1);
                                n_total       = r_total + r_val;
                                n_out_word.ok = 1'b1;
                            end
                        end
                        rfs_pkg::OP_PUSH: begin
                            // Drop the oldest word when full, then append.
                            mem_req.we    = 1'b1;
                            n_wr          = r_wr + IW'(1);
                            n_out_word.ok = 1'b1;
                            if (held >= cap) begin
                                n_rd    = r_rd + IW'(1);
                                n_total = r_total + r_val - mem_rdata;
                            end else begin
                                n_total = r_total + r_val;
                            end
                        end
                        rfs_pkg::OP_GET: begin
                            if (held != '0) begin
                                n_rd            = r_rd + IW'(1);
                                n_total         = r_total - mem_rdata;
                                n_out_word.ok   = 1'b1;
                                n_out_word.data = mem_rdata;
                            end
                        end
                        rfs_pkg::OP_PEEK_NEW,
                        rfs_pkg::OP_PEEK_OLD: begin
                            if (held != '0) begin
                                n_out_word.ok   = 1'b1;
                                n_out_word.data = mem_rdata;
                            end
                        end
                        default: begin
                            // unknown op: report state unchanged
                        end
                    endcase
                    held_new            = n_wr - n_rd;
                    n_out_word.count    = rfs_pkg::CNT_W'(held_new);
                    n_out_word.total    = n_total;
                    n_out_word.is_empty = (held_new == '0);
                    n_out_word.is_full  = (held_new == cap);
                end
            end
            default: begin
                n_state = rfs_pkg::S_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rfs_pkg::S_IDLE;
            r_size      <= rfs_pkg::SIZE_RESET;
            r_wr        <= '0;
            r_rd        <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            // A size write empties the queue.
            if (cfg_acc) begin
                r_size  <= i_cfg_data;
                r_wr    <= '0;
                r_rd    <= '0;
                r_total <= '0;
            end else begin
                r_wr    <= n_wr;
                r_rd    <= n_rd;
                r_total <= n_total;
            end
            if (fin) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload: latch the op on acceptance, the result on finish.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op  <= i_in_word.op;
            r_val <= i_in_word.value;
        end
        if (fin) begin
            r_out_word <= n_out_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_held_le_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        held <= cap)
        else $error("queue holds more words than its capacity");

    a_acc_to_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == rfs_pkg::S_FIN))
        else $error("accepted word did not enter the finish state");

    a_total_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rfs_pkg::S_IDLE && !cfg_acc) |=> $stable(r_total))
        else $error("running total changed with no word finishing");

endmodule

/* sv/rfs_store.sv */
// Entry store of the ring FIFO: one write port, one read port with a
// registered read. Depends on rfs_pkg.
module rfs_store (
    input  logic                          i_clk,
    input  rfs_pkg::t_mem_req             i_req,
    output logic [rfs_pkg::DATA_W-1:0]    o_rdata
);

    logic [rfs_pkg::DATA_W-1:0] r_mem [rfs_pkg::MAX_DEPTH];
    logic [rfs_pkg::DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
    end

    // Hold read data until the next read.
    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* tb/sv/ring_fifo_sum_checker.sv */
`timescale 1ns / 100ps
// Checker for ring_fifo_with_running_sum: watches the size, op and result channels,
// predicts each result word and compares it field by field. Depends on rfs_pkg.
module ring_fifo_sum_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    input  logic                        i_cfg_ready,
    input  logic [rfs_pkg::SIZE_W-1:0]  i_cfg_data,
    input  logic                        i_in_valid,
    input  logic                        i_in_ready,
    input  rfs_pkg::t_in_word           i_in_word,
    input  logic                        i_out_valid,
    input  logic                        i_out_ready,
    input  rfs_pkg::t_out_word          i_out_word,
    output int                          o_errors,
    output int                          o_pending
);

    // Shadow copy of the queue.
    logic [rfs_pkg::DATA_W-1:0] held_words [rfs_pkg::MAX_DEPTH];
    logic [rfs_pkg::IDX_W-1:0]  wr_ptr;
    logic [rfs_pkg::IDX_W-1:0]  rd_ptr;
    logic [rfs_pkg::DATA_W-1:0] sum_q;
    logic [rfs_pkg::SIZE_W-1:0] size_q;
    rfs_pkg::t_out_word         due_results [$];
    int                         mismatches = 0;

    assign o_errors = mismatches;

    // Sizes of 0 act as 1; sizes past the store saturate at its depth.
    function automatic int unsigned capacity_of(input logic [rfs_pkg::SIZE_W-1:0] lg_in);
        int unsigned lg;
        int unsigned cap;
        lg  = (lg_in == '0) ? 1 : lg_in;
        cap = 1 << lg;
        while (cap > rfs_pkg::MAX_DEPTH) cap = cap >> 1;
        return cap;
    endfunction

    // Apply one op to the shadow queue and return the result word it yields.
    function automatic rfs_pkg::t_out_word apply_op(input rfs_pkg::t_in_word w);
        rfs_pkg::t_out_word        r;
        int unsigned               cap;
        logic [rfs_pkg::IDX_W-1:0] mask;
        logic [rfs_pkg::IDX_W-1:0] n;
        cap  = capacity_of(size_q);
        mask = rfs_pkg::IDX_W'(cap - 1);
        n    = wr_ptr - rd_ptr;
        r    = '0;
        case (w.op)
            rfs_pkg::OP_PUT: begin
                if (n < cap) begin
                    held_words[rfs_pkg::ADDR_W'(wr_ptr & mask)] = w.value;
                    wr_ptr = wr_ptr + 1'b1;
                    sum_q  = sum_q + w.value;
                    r.ok   = 1'b1;
                end
            end
            rfs_pkg::OP_PUSH: begin
                // drop the oldest word first when full
                if (n >= cap) begin
                    sum_q  = sum_q - held_words[rfs_pkg::ADDR_W'(rd_ptr & mask)];
                    rd_ptr = rd_ptr + 1'b1;
                end
                held_words[rfs_pkg::ADDR_W'(wr_ptr & mask)] = w.value;
                wr_ptr = wr_ptr + 1'b1;
                sum_q  = sum_q + w.value;
                r.ok   = 1'b1;
            end
            rfs_pkg::OP_GET: begin
                if (n != 0) begin
                    r.data = held_words[rfs_pkg::ADDR_W'(rd_ptr & mask)];
                    rd_ptr = rd_ptr + 1'b1;
                    sum_q  = sum_q - r.data;
                    r.ok   = 1'b1;
                end
            end
            rfs_pkg::OP_PEEK_NEW: begin
                if (n != 0) begin
                    r.data = held_words[rfs_pkg::ADDR_W'((wr_ptr - 1'b1) & mask)];
                    r.ok   = 1'b1;
                end
            end
            rfs_pkg::OP_PEEK_OLD: begin
                if (n != 0) begin
                    r.data = held_words[rfs_pkg::ADDR_W'(rd_ptr & mask)];
                    r.ok   = 1'b1;
                end
            end
            default: ;
        endcase
        n          = wr_ptr - rd_ptr;
        r.count    = rfs_pkg::CNT_W'(n);
        r.total    = sum_q;
        r.is_empty = (n == 0);
        r.is_full  = (n == cap);
        return r;
    endfunction

    task automatic check_field(input string name, input logic signed [63:0] want,
                               input logic signed [63:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        rfs_pkg::t_out_word want;
        if (!i_rst_n) begin
            wr_ptr = '0;
            rd_ptr = '0;
            sum_q  = '0;
            size_q = rfs_pkg::SIZE_RESET;
            due_results.delete();
        end else begin
            // Compare before predicting: a result never leaves on its op's own edge.
            if (i_out_valid && i_out_ready) begin
                if (due_results.size() == 0) begin
                    $display("%0t: result word with nothing outstanding, actual %p",
                             $time, i_out_word);
                    mismatches++;
                end else begin
                    want = due_results.pop_front();
                    check_field("ok", want.ok, i_out_word.ok);
                    check_field("data", want.data, i_out_word.data);
                    check_field("count", want.count, i_out_word.count);
                    check_field("total", want.total, i_out_word.total);
                    check_field("is_empty", want.is_empty, i_out_word.is_empty);
                    check_field("is_full", want.is_full, i_out_word.is_full);
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                size_q = i_cfg_data;
                wr_ptr = '0;
                rd_ptr = '0;
                sum_q  = '0;
            end
            if (i_in_valid && i_in_ready) due_results.push_back(apply_op(i_in_word));
        end
        o_pending <= due_results.size();
    end

endmodule

/* tb/sv/tb_ring_fifo_with_running_sum.sv */
`timescale 1ns / 100ps
// Top of the ring_fifo_with_running_sum testbench: clock, reset, stimulus and verdict.
// Depends on rfs_pkg, the block and ring_fifo_sum_checker.
module tb_ring_fifo_with_running_sum;

    localparam int ITEMS  = 1550;
    localparam int PHASES = 12;
    // Op codes the block treats as no operation.
    localparam logic [2:0] OP_BAD_LO  = 3'd5;
    localparam logic [2:0] OP_BAD_MID = 3'd6;
    localparam logic [2:0] OP_BAD_HI  = 3'd7;
    localparam logic [rfs_pkg::DATA_W-1:0] W_MAX  = 32'h7fff_ffff;
    localparam logic [rfs_pkg::DATA_W-1:0] W_MIN  = 32'h8000_0000;
    localparam logic [rfs_pkg::DATA_W-1:0] W_ONES = 32'hffff_ffff;

    logic                       i_clk       = 1'b0;
    logic                       i_rst_n     = 1'b0;
    logic                       i_cfg_valid = 1'b0;
    logic [rfs_pkg::SIZE_W-1:0] i_cfg_data  = '0;
    logic                       i_in_valid  = 1'b0;
    rfs_pkg::t_in_word          i_in_word   = '0;
    logic                       i_out_ready = 1'b0;
    logic                       o_cfg_ready;
    logic                       o_in_ready;
    logic                       o_out_valid;
    rfs_pkg::t_out_word         o_out_word;

    int errors;
    int pending;
    // Idle rates in percent; start with a mostly stalled receiver.
    int tx_idle_pct = 10;
    int rx_idle_pct = 81;
    int sent        = 0;

    always #10 i_clk = ~i_clk;

    ring_fifo_with_running_sum uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

    ring_fifo_sum_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .i_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .i_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_out_word  (o_out_word),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    // Stall the result side at random, at the current rate.
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // Hard stop well past the slowest legal run.
    initial begin
        #20_000_000;
        $display("FAIL ring_fifo_with_running_sum");
        $finish;
    end

    // Offer one op word after a random gap; hold it until the block takes it.
    task automatic send_op(input logic [2:0] op, input logic [rfs_pkg::DATA_W-1:0] value);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= '{op: op, value: value};
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sent++;
        // Swap the idle pattern a third of the way in, then drop idling at two thirds.
        if (sent == ITEMS / 3) begin
            tx_idle_pct = 81;
            rx_idle_pct = 10;
        end else if (sent == 2 * ITEMS / 3) begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
        end
    endtask

    // Drop valid, wait for every outstanding result, then let the pipe settle.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Write size_log2 only once the block is idle.
    task automatic write_size(input logic [rfs_pkg::SIZE_W-1:0] lg);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= lg;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Mostly random words, with the extremes mixed in.
    function automatic logic [rfs_pkg::DATA_W-1:0] pick_value();
        if ($urandom_range(7) != 0) return $urandom;
        case ($urandom_range(3))
            0:       return W_MAX;
            1:       return W_MIN;
            2:       return W_ONES;
            default: return '0;
        endcase
    endfunction

    // Filling bursts lean on put and push, draining bursts on get; a few unknown ops.
    function automatic logic [2:0] pick_op(input bit filling);
        int r;
        r = $urandom_range(99);
        if (r >= 95) return 3'($urandom_range(OP_BAD_LO, OP_BAD_HI));
        if (filling) begin
            if (r < 45) return rfs_pkg::OP_PUT;
            if (r < 80) return rfs_pkg::OP_PUSH;
            if (r < 85) return rfs_pkg::OP_GET;
            if (r < 90) return rfs_pkg::OP_PEEK_NEW;
            return rfs_pkg::OP_PEEK_OLD;
        end
        if (r < 10) return rfs_pkg::OP_PUT;
        if (r < 20) return rfs_pkg::OP_PUSH;
        if (r < 70) return rfs_pkg::OP_GET;
        if (r < 80) return rfs_pkg::OP_PEEK_NEW;
        return rfs_pkg::OP_PEEK_OLD;
    endfunction

    initial begin
        logic [rfs_pkg::SIZE_W-1:0] lg;
        int                         burst;
        bit                         filling;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset size: refused get and peeks on an empty queue, extreme words
        // and the unknown op codes.
        send_op(rfs_pkg::OP_GET, W_MAX);
        send_op(rfs_pkg::OP_PEEK_NEW, W_MIN);
        send_op(rfs_pkg::OP_PEEK_OLD, W_ONES);
        send_op(rfs_pkg::OP_PUT, W_MAX);
        send_op(rfs_pkg::OP_PUT, W_MIN);
        send_op(rfs_pkg::OP_PEEK_NEW, '0);
        send_op(rfs_pkg::OP_PEEK_OLD, '0);
        send_op(OP_BAD_LO, W_MAX);
        send_op(OP_BAD_MID, W_MIN);
        send_op(OP_BAD_HI, W_ONES);
        send_op(rfs_pkg::OP_GET, '0);

        // Smallest queue: refused put when full, push dropping the oldest word,
        // get running it dry.
        write_size(rfs_pkg::SIZE_MIN);
        send_op(rfs_pkg::OP_PUT, 32'd1);
        send_op(rfs_pkg::OP_PUSH, W_ONES);
        send_op(rfs_pkg::OP_PUT, 32'd5);
        send_op(rfs_pkg::OP_PUSH, W_MAX);
        send_op(rfs_pkg::OP_PUSH, W_MIN);
        send_op(rfs_pkg::OP_PEEK_NEW, '0);
        send_op(rfs_pkg::OP_PEEK_OLD, '0);
        send_op(rfs_pkg::OP_GET, '0);
        send_op(rfs_pkg::OP_GET, '0);
        send_op(rfs_pkg::OP_GET, '0);
        send_op(rfs_pkg::OP_PEEK_OLD, '0);
        send_op(rfs_pkg::OP_PUSH, '0);

        // Random phases; the size steps 3,0,5,2,7,4,1,6 and round again,
        // so every code, in range or not, gets its turn.
        for (int ph = 0; ph < PHASES; ph++) begin
            lg = rfs_pkg::SIZE_W'((ph * 5 + 3) % 8);
            write_size(lg);
            filling = 1'b0;
            burst   = 0;
            for (int k = 0; k < ITEMS / PHASES; k++) begin
                // Alternate fill and drain bursts long enough to hit full and empty.
                if (burst == 0) begin
                    filling = ~filling;
                    burst   = $urandom_range(1, 2 << lg);
                end
                burst--;
                send_op(pick_op(filling), pick_value());
            end
        end

        wait_idle();
        if (errors == 0) begin
            $display("PASS ring_fifo_with_running_sum");
        end else begin
            $display("FAIL ring_fifo_with_running_sum");
        end
        $finish;
    end

endmodule
